@@ design/fia_pkg.sv @@
// Shared types, opcodes and character constants for the format item converter.
`timescale 1ns / 1ps
`default_nettype none

package fia_pkg;

   localparam int DEC_DIGITS = 10;
   localparam int HEX_DIGITS_N = 8;
   localparam int MAX_CHARS = 11;

   typedef enum logic [2:0] {
      OP_LITERAL = 3'd0,
      OP_ESCAPE  = 3'd1,
      OP_DECIMAL = 3'd2,
      OP_HEX_MIN = 3'd3,
      OP_HEX_PAD = 3'd4
   } fia_op_type;

   localparam logic [15:0][7:0] HEX_DIGITS = "FEDCBA9876543210";

   localparam logic [7:0] CHAR_MINUS     = 8'h2d;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_A = 8'h61;
   localparam logic [7:0] CHAR_B = 8'h62;
   localparam logic [7:0] CHAR_T = 8'h74;
   localparam logic [7:0] CHAR_N = 8'h6e;
   localparam logic [7:0] CHAR_V = 8'h76;
   localparam logic [7:0] CHAR_F = 8'h66;
   localparam logic [7:0] CHAR_R = 8'h72;

   localparam logic [7:0] CODE_BELL = 8'd7;
   localparam logic [7:0] CODE_BS   = 8'd8;
   localparam logic [7:0] CODE_TAB  = 8'd9;
   localparam logic [7:0] CODE_LF   = 8'd10;
   localparam logic [7:0] CODE_VT   = 8'd11;
   localparam logic [7:0] CODE_FF   = 8'd12;
   localparam logic [7:0] CODE_CR   = 8'd13;

   // Reciprocal of ten, exact for every 32-bit dividend after a shift by 35.
   localparam logic [31:0] RECIP_TEN = 32'hcccc_cccd;
   localparam int RECIP_SHIFT = 35;

   typedef logic [MAX_CHARS-1:0][7:0] fia_chars_type;

   typedef struct packed {
      fia_op_type                      opcode;
      logic [7:0]                      char_in;
      logic [31:0]                     word;
      logic                            neg;
      logic [31:0]                     rem;
      logic [DEC_DIGITS-1:0][3:0]      digits;
   } fia_pipe_type;

   function automatic logic [7:0] nibble_to_ascii(input logic [3:0] nib);
      return HEX_DIGITS[nib];
   endfunction

endpackage

`default_nettype wire

@@ design/format_item_to_ascii_core.sv @@
// Top level of the format item to ASCII converter.
// Requests pass the input register, the digit stages and the pack stage to the shifter.
// Throughput: one character per cycle while rsp_stall is low; a request holds the output
// shifter until all its characters leave; the 12-stage pipeline advances only as it frees.
// Reset clears all valid bits and the output character count; no data is cleared.
`timescale 1ns / 1ps
`default_nettype none

module format_item_to_ascii_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [2:0]   req_opcode,
   input  wire logic [7:0]   req_char_in,
   input  wire logic [31:0]  req_number,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [7:0]        rsp_out_char,
   output logic              rsp_last
);
   import fia_pkg::*;

   logic            en;
   logic            load;
   logic            vld [0:DEC_DIGITS];
   fia_pipe_type    pipe [0:DEC_DIGITS];
   fia_pipe_type    pipe0_in;
   logic            vld0_ff;
   fia_pipe_type    pipe0_ff;
   logic            pack_vld;
   fia_chars_type   pack_chars;
   logic [3:0]      pack_count;

   // The whole pipeline moves together whenever its last stage is empty or drains.
   assign en        = !pack_vld || load;
   assign req_stall = !en;

   always_comb begin
      pipe0_in         = '0;
      pipe0_in.opcode  = fia_op_type'(req_opcode);
      pipe0_in.char_in = req_char_in;
      pipe0_in.word    = req_number;
      pipe0_in.neg     = (fia_op_type'(req_opcode) == OP_DECIMAL) && req_number[31];
      pipe0_in.rem     = pipe0_in.neg ? (32'd0 - req_number) : req_number;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (en) begin
         vld0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pipe0_ff <= pipe0_in;
      end
   end

   assign vld[0]  = vld0_ff;
   assign pipe[0] = pipe0_ff;

   for (genvar s = 0; s < DEC_DIGITS; s++) begin : g_div
      fia_div10_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .vld_in   (vld[s]),
         .pipe_in  (pipe[s]),
         .vld_out  (vld[s+1]),
         .pipe_out (pipe[s+1])
      );
   end

   fia_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .vld_in    (vld[DEC_DIGITS]),
      .pipe_in   (pipe[DEC_DIGITS]),
      .vld_out   (pack_vld),
      .chars_out (pack_chars),
      .count_out (pack_count)
   );

   fia_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .pack_vld     (pack_vld),
      .pack_chars   (pack_chars),
      .pack_count   (pack_count),
      .load         (load),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

@@ design/fia_div10_stage.sv @@
// One pipeline stage that peels off the lowest decimal digit of the running quotient.
`timescale 1ns / 1ps
`default_nettype none

module fia_div10_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  vld_in,
   input  wire fia_pkg::fia_pipe_type pipe_in,
   output logic                       vld_out,
   output fia_pkg::fia_pipe_type      pipe_out
);
   import fia_pkg::*;

   logic [63:0]       prod;
   logic [31:0]       quot;
   logic [31:0]       quot_x10;
   logic [31:0]       diff;
   logic              vld_ff;
   fia_pipe_type      pipe_ff;
   fia_pipe_type      pipe_in_next;

   always_comb begin
      prod     = 64'(pipe_in.rem) * 64'(RECIP_TEN);
      quot     = 32'(prod[63:RECIP_SHIFT]);
      quot_x10 = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
      diff     = pipe_in.rem - quot_x10;
      pipe_in_next        = pipe_in;
      pipe_in_next.rem    = quot;
      // New digits enter at the top, so the first one computed ends up at index zero.
      pipe_in_next.digits = {diff[3:0], pipe_in.digits[DEC_DIGITS-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff <= pipe_in_next;
      end
   end

   assign vld_out  = vld_ff;
   assign pipe_out = pipe_ff;

endmodule

`default_nettype wire

@@ design/fia_pack.sv @@
// Final pipeline stage that lays out the characters of one item and counts them.
`timescale 1ns / 1ps
`default_nettype none

module fia_pack (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   vld_in,
   input  wire fia_pkg::fia_pipe_type  pipe_in,
   output logic                        vld_out,
   output fia_pkg::fia_chars_type      chars_out,
   output logic [3:0]                  count_out
);
   import fia_pkg::*;

   logic                           vld_ff;
   fia_chars_type                  chars_ff;
   fia_chars_type                  chars_in;
   logic [3:0]                     count_ff;
   logic [3:0]                     count_in;
   logic [3:0]                     dec_len;
   logic [3:0]                     hex_len;
   logic [HEX_DIGITS_N-1:0][3:0]   nibs;
   logic [5:0]                     dpos;
   logic [4:0]                     hpos;

   always_comb begin
      nibs    = pipe_in.word;
      dec_len = 4'd1;
      hex_len = 4'd1;
      for (int k = 0; k < DEC_DIGITS; k++) begin
         if (pipe_in.digits[k] != 4'd0) begin
            dec_len = 4'(k + 1);
         end
      end
      for (int k = 0; k < HEX_DIGITS_N; k++) begin
         if (nibs[k] != 4'd0) begin
            hex_len = 4'(k + 1);
         end
      end

      chars_in = '0;
      count_in = 4'd0;
      dpos     = 6'd0;
      hpos     = 5'd0;
      case (pipe_in.opcode)
         OP_LITERAL: begin
            chars_in[0] = pipe_in.char_in;
            count_in    = 4'd1;
         end
         OP_ESCAPE: begin
            count_in = 4'd1;
            case (pipe_in.char_in)
               CHAR_A:         chars_in[0] = CODE_BELL;
               CHAR_B:         chars_in[0] = CODE_BS;
               CHAR_T:         chars_in[0] = CODE_TAB;
               CHAR_N:         chars_in[0] = CODE_LF;
               CHAR_V:         chars_in[0] = CODE_VT;
               CHAR_F:         chars_in[0] = CODE_FF;
               CHAR_R:         chars_in[0] = CODE_CR;
               CHAR_BACKSLASH: chars_in[0] = CHAR_BACKSLASH;
               default:        count_in    = 4'd0;
            endcase
         end
         OP_DECIMAL: begin
            // Slot j holds digit dec_len-1-(j-neg); out-of-range positions wrap high.
            for (int j = 0; j < MAX_CHARS; j++) begin
               dpos = 6'(dec_len) + 6'(pipe_in.neg) - 6'(j) - 6'd1;
               if (pipe_in.neg && j == 0) begin
                  chars_in[j] = CHAR_MINUS;
               end else if (dpos < 6'(DEC_DIGITS)) begin
                  chars_in[j] = nibble_to_ascii(pipe_in.digits[dpos[3:0]]);
               end
            end
            count_in = dec_len + 4'(pipe_in.neg);
         end
         OP_HEX_MIN: begin
            for (int j = 0; j < HEX_DIGITS_N; j++) begin
               hpos = 5'(hex_len) - 5'(j) - 5'd1;
               if (hpos < 5'(HEX_DIGITS_N)) begin
                  chars_in[j] = nibble_to_ascii(nibs[hpos[2:0]]);
               end
            end
            count_in = hex_len;
         end
         OP_HEX_PAD: begin
            for (int j = 0; j < HEX_DIGITS_N; j++) begin
               chars_in[j] = nibble_to_ascii(nibs[HEX_DIGITS_N-1-j]);
            end
            count_in = 4'(HEX_DIGITS_N);
         end
         default: begin
            count_in = 4'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         chars_ff <= chars_in;
         count_ff <= count_in;
      end
   end

   assign vld_out   = vld_ff;
   assign chars_out = chars_ff;
   assign count_out = count_ff;

endmodule

`default_nettype wire

@@ design/fia_emit.sv @@
// Output shifter that hands out the characters of one item, one per cycle while rsp_stall is low.
`timescale 1ns / 1ps
`default_nettype none

module fia_emit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   pack_vld,
   input  wire fia_pkg::fia_chars_type pack_chars,
   input  wire logic [3:0]             pack_count,
   output logic                        load,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_out_char,
   output logic                        rsp_last
);
   import fia_pkg::*;

   fia_chars_type  chars_ff;
   fia_chars_type  chars_in;
   logic [3:0]     count_ff;
   logic [3:0]     count_in;
   logic           fire;
   logic           free;

   assign fire = (count_ff != 4'd0) && !rsp_stall;
   // The next item may load in the same cycle the final character leaves.
   assign free = (count_ff == 4'd0) || ((count_ff == 4'd1) && fire);
   assign load = pack_vld && free;

   always_comb begin
      chars_in = chars_ff;
      count_in = count_ff;
      if (load) begin
         chars_in = pack_chars;
         count_in = pack_count;
      end else if (fire) begin
         chars_in = {8'd0, chars_ff[MAX_CHARS-1:1]};
         count_in = count_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
   end

   assign rsp_valid    = count_ff != 4'd0;
   assign rsp_out_char = chars_ff[0];
   assign rsp_last     = count_ff == 4'd1;

endmodule

`default_nettype wire
